[rtl/kfilt_pkg.sv]
`default_nettype none

package kfilt_pkg;

    localparam int SENDER_ENTRIES = 16;
    localparam int ENTRY_IDX_W    = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1;
    localparam int GUARDED_PORTS  = 4;
    localparam int GUARD_REGS     = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int PORT_W         = 16;
    localparam int ADDR_W         = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [GUARD_REGS-1:0] GUARD_USE = GUARD_REGS'((1 << GUARDED_PORTS) - 1);

    localparam logic [PORT_W-1:0] KNOCK_FIRST_RST  = 16'd2345;
    localparam logic [PORT_W-1:0] KNOCK_SECOND_RST = 16'd3456;
    localparam logic [PORT_W-1:0] KNOCK_THIRD_RST  = 16'd4567;

    localparam logic [1:0] PROG_DONE = 2'd3;

    localparam logic VERDICT_ACCEPT = 1'b0;
    localparam logic VERDICT_DROP   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KNOCK_FIRST  = 3'd0,
        CFG_KNOCK_SECOND = 3'd1,
        CFG_KNOCK_THIRD  = 3'd2,
        CFG_GUARD_A      = 3'd3,
        CFG_GUARD_B      = 3'd4,
        CFG_GUARD_C      = 3'd5,
        CFG_GUARD_D      = 3'd6,
        CFG_GUARD_MASK   = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        R_NO_GUARD    = 3'd0,
        R_NOT_TCP     = 3'd1,
        R_UNWATCHED   = 3'd2,
        R_AUTHORIZED  = 3'd3,
        R_REFUSED     = 3'd4,
        R_KNOCK_ADV   = 3'd5,
        R_KNOCK_WRONG = 3'd6,
        R_TABLE_FULL  = 3'd7
    } t_reason;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_GUARD = 2'd1,
        KIND_KNOCK = 2'd2
    } t_kind;

    typedef struct packed {
        logic [PORT_W-1:0]                  knock_first;
        logic [PORT_W-1:0]                  knock_second;
        logic [PORT_W-1:0]                  knock_third;
        logic [GUARD_REGS-1:0][PORT_W-1:0]  guard_port;
        logic [GUARD_REGS-1:0]              guard_mask;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        t_reason           reason;
        logic              v6;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [2:0]        keq;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

[rtl/kfilt_in_if.sv]
`default_nettype none

interface kfilt_in_if
    import kfilt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ip_version;
    logic              is_tcp;
    logic [ADDR_W-1:0] src_addr_high;
    logic [ADDR_W-1:0] src_addr_low;
    logic [PORT_W-1:0] dest_port;

    modport source (
        output valid, ip_version, is_tcp, src_addr_high, src_addr_low, dest_port,
        input  ready
    );

    modport sink (
        input  valid, ip_version, is_tcp, src_addr_high, src_addr_low, dest_port,
        output ready
    );
endinterface

`default_nettype wire

[rtl/kfilt_out_if.sv]
`default_nettype none

interface kfilt_out_if;
    logic       valid;
    logic       ready;
    logic       verdict;
    logic [2:0] reason;

    modport source (
        output valid, verdict, reason,
        input  ready
    );

    modport sink (
        input  valid, verdict, reason,
        output ready
    );
endinterface

`default_nettype wire

[rtl/tcp_port_knock_filter_unit.sv]
`default_nettype none

// Channel  | Dir | Handshake           | Payload
// i_pkt    | in  | valid / ready       | ip_version, is_tcp, src_addr_high/low, dest_port
// o_res    | out | valid / ready       | verdict, reason
// i_cfg_*  | in  | i_cfg_we, no ready  | i_cfg_idx selects register, i_cfg_data
//
// One item per cycle sustained while the queue has room and results drain.
// Each item is registered in the queue before the back end registers its result.
// The back end's table lookup is combinational; updates register with the result.
// A two-item queue separates classification from the table; i_pkt.ready
// drops only when that queue is full, and a held result stalls the back
// end while o_res.ready is low. Synchronous reset clears the sender
// table valid bits, the queue and the result register, and restores config.

module tcp_port_knock_filter_unit
    import kfilt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kfilt_in_if.sink              i_pkt,
    kfilt_out_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    push;
    logic    pop;
    t_job    front_job;
    t_job    head_job;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.knock_first  <= KNOCK_FIRST_RST;
            r_cfg.knock_second <= KNOCK_SECOND_RST;
            r_cfg.knock_third  <= KNOCK_THIRD_RST;
            r_cfg.guard_port   <= '0;
            r_cfg.guard_mask   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_KNOCK_FIRST:  r_cfg.knock_first   <= i_cfg_data;
                CFG_KNOCK_SECOND: r_cfg.knock_second  <= i_cfg_data;
                CFG_KNOCK_THIRD:  r_cfg.knock_third   <= i_cfg_data;
                CFG_GUARD_A:      r_cfg.guard_port[0] <= i_cfg_data;
                CFG_GUARD_B:      r_cfg.guard_port[1] <= i_cfg_data;
                CFG_GUARD_C:      r_cfg.guard_port[2] <= i_cfg_data;
                CFG_GUARD_D:      r_cfg.guard_port[3] <= i_cfg_data;
                CFG_GUARD_MASK:   r_cfg.guard_mask    <= i_cfg_data[GUARD_REGS-1:0];
                default: ;
            endcase
        end
    end

    kfilt_front u_front (
        .i_pkt    (i_pkt),
        .i_cfg    (r_cfg),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_job    (front_job)
    );

    kfilt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    kfilt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_valid (!q_stat.empty),
        .o_pop     (pop),
        .o_res     (o_res)
    );

    // drops come only from the guarded or knock paths
    a_drop_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.verdict == VERDICT_DROP) |->
        (o_res.reason == R_REFUSED || o_res.reason == R_KNOCK_ADV ||
         o_res.reason == R_KNOCK_WRONG || o_res.reason == R_TABLE_FULL))
        else $error("drop with an accept reason");

    // nothing queued, so no new result can appear
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |=> !$rose(o_res.valid))
        else $error("result without a queued item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res.valid && q_stat.empty))
        else $error("result or queue not cleared by reset");

endmodule

`default_nettype wire

[rtl/kfilt_front.sv]
`default_nettype none

module kfilt_front
    import kfilt_pkg::*;
(
    kfilt_in_if.sink    i_pkt,
    input  t_cfg        i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [GUARD_REGS-1:0] mask;
    logic                  guarded;
    logic [2:0]            keq;

    assign mask = i_cfg.guard_mask & GUARD_USE;

    always_comb begin
        guarded = 1'b0;
        for (int g = 0; g < GUARD_REGS; g++) begin
            if (mask[g] && i_pkt.dest_port == i_cfg.guard_port[g]) begin
                guarded = 1'b1;
            end
        end
    end

    assign keq[0] = (i_pkt.dest_port == i_cfg.knock_first);
    assign keq[1] = (i_pkt.dest_port == i_cfg.knock_second);
    assign keq[2] = (i_pkt.dest_port == i_cfg.knock_third);

    always_comb begin
        o_job.v6  = i_pkt.ip_version;
        o_job.keq = keq;
        // IPv4 senders key on the low 32 address bits only
        o_job.hi  = i_pkt.ip_version ? i_pkt.src_addr_high : '0;
        o_job.lo  = i_pkt.ip_version ? i_pkt.src_addr_low
                                     : {32'b0, i_pkt.src_addr_low[31:0]};
        o_job.kind   = KIND_DONE;
        o_job.reason = R_NO_GUARD;
        if (mask == '0) begin
            o_job.reason = R_NO_GUARD;
        end else if (!i_pkt.is_tcp) begin
            o_job.reason = R_NOT_TCP;
        end else if (guarded) begin
            o_job.kind = KIND_GUARD;
        end else if (keq == 3'b000) begin
            o_job.reason = R_UNWATCHED;
        end else begin
            o_job.kind = KIND_KNOCK;
        end
    end

    assign i_pkt.ready = !i_q_full;
    assign o_push      = i_pkt.valid && !i_q_full;

endmodule

`default_nettype wire

[rtl/kfilt_queue.sv]
`default_nettype none

module kfilt_queue
    import kfilt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_job     i_job,
    input  logic     i_pop,
    output t_job     o_job,
    output t_q_stat  o_stat
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[rtl/kfilt_back.sv]
`default_nettype none

module kfilt_back
    import kfilt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_q_valid,
    output logic        o_pop,
    kfilt_out_if.source o_res
);

    logic [SENDER_ENTRIES-1:0] r_ent_valid;
    logic                      r_ent_v6   [SENDER_ENTRIES];
    logic [ADDR_W-1:0]         r_ent_hi   [SENDER_ENTRIES];
    logic [ADDR_W-1:0]         r_ent_lo   [SENDER_ENTRIES];
    logic [1:0]                r_ent_prog [SENDER_ENTRIES];

    logic    r_out_valid;
    logic    r_verdict, n_verdict;
    t_reason r_reason, n_reason;

    logic                   take;
    logic                   hit;
    logic [ENTRY_IDX_W-1:0] hit_idx;
    logic                   free_found;
    logic [ENTRY_IDX_W-1:0] free_idx;
    logic [1:0]             hit_prog;
    logic                   knock_ok;
    logic                   tbl_clear;
    logic                   tbl_adv;
    logic                   tbl_new;

    assign take  = i_q_valid && (!r_out_valid || o_res.ready);
    assign o_pop = take;

    // parallel sender match; scanning downward leaves the lowest index
    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SENDER_ENTRIES - 1; i >= 0; i--) begin
            if (r_ent_valid[i] && r_ent_v6[i] == i_job.v6 &&
                r_ent_hi[i] == i_job.hi && r_ent_lo[i] == i_job.lo) begin
                hit     = 1'b1;
                hit_idx = ENTRY_IDX_W'(i);
            end
            if (!r_ent_valid[i]) begin
                free_found = 1'b1;
                free_idx   = ENTRY_IDX_W'(i);
            end
        end
    end

    assign hit_prog = r_ent_prog[hit_idx];

    always_comb begin
        case (hit_prog)
            2'd0:    knock_ok = i_job.keq[0];
            2'd1:    knock_ok = i_job.keq[1];
            2'd2:    knock_ok = i_job.keq[2];
            default: knock_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_verdict = VERDICT_ACCEPT;
        n_reason  = i_job.reason;
        tbl_clear = 1'b0;
        tbl_adv   = 1'b0;
        tbl_new   = 1'b0;
        case (i_job.kind)
            KIND_GUARD: begin
                if (hit && hit_prog == PROG_DONE) begin
                    n_reason = R_AUTHORIZED;
                end else begin
                    n_verdict = VERDICT_DROP;
                    n_reason  = R_REFUSED;
                end
            end
            KIND_KNOCK: begin
                n_verdict = VERDICT_DROP;
                if (hit) begin
                    if (knock_ok) begin
                        tbl_adv  = 1'b1;
                        n_reason = R_KNOCK_ADV;
                    end else begin
                        tbl_clear = 1'b1;
                        n_reason  = R_KNOCK_WRONG;
                    end
                end else if (free_found) begin
                    // a new sender with a wrong first knock is never recorded
                    tbl_new  = i_job.keq[0];
                    n_reason = i_job.keq[0] ? R_KNOCK_ADV : R_KNOCK_WRONG;
                end else begin
                    n_reason = R_TABLE_FULL;
                end
            end
            default: begin
                n_verdict = VERDICT_ACCEPT;
                n_reason  = i_job.reason;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && tbl_clear) begin
                r_ent_valid[hit_idx] <= 1'b0;
            end
            if (take && tbl_new) begin
                r_ent_valid[free_idx] <= 1'b1;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && tbl_adv) begin
            r_ent_prog[hit_idx] <= hit_prog + 2'd1;
        end
        if (take && tbl_new) begin
            r_ent_v6[free_idx]   <= i_job.v6;
            r_ent_hi[free_idx]   <= i_job.hi;
            r_ent_lo[free_idx]   <= i_job.lo;
            r_ent_prog[free_idx] <= 2'd1;
        end
        if (take) begin
            r_verdict <= n_verdict;
            r_reason  <= n_reason;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.verdict = r_verdict;
    assign o_res.reason  = r_reason;

endmodule

`default_nettype wire

[tb/tb_tcp_port_knock_filter_unit.sv]
`default_nettype none

module tb_tcp_port_knock_filter_unit;
    import kfilt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 22;
    localparam int POOL_V4     = 11;

    typedef struct {
        logic    verdict;
        t_reason reason;
    } t_outcome;

    logic clk;
    logic rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    kfilt_in_if  pkt_if ();
    kfilt_out_if res_if ();

    tcp_port_knock_filter_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pkt      (pkt_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // filter settings as the block should hold them
    logic [PORT_W-1:0] knock_seq [3];
    logic [PORT_W-1:0] guard_port [GUARD_REGS];
    logic [GUARD_REGS-1:0] guard_mask;

    // sender table copy
    logic              sender_valid [SENDER_ENTRIES];
    logic              sender_v6    [SENDER_ENTRIES];
    logic [ADDR_W-1:0] sender_hi    [SENDER_ENTRIES];
    logic [ADDR_W-1:0] sender_lo    [SENDER_ENTRIES];
    logic [1:0]        sender_step  [SENDER_ENTRIES];

    // random sender pool
    logic              pool_v6 [POOL_SIZE];
    logic [ADDR_W-1:0] pool_hi [POOL_SIZE];
    logic [ADDR_W-1:0] pool_lo [POOL_SIZE];

    t_outcome verdict_q [$];

    int mismatches;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, verdict_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side ready; a long hold-off overrides the random stalls
    always @(negedge clk) begin
        if (hold_left > 0) begin
            res_if.ready = 1'b0;
            hold_left--;
        end else begin
            res_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge clk) begin
        t_outcome want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result verdict=%0b reason=%0d",
                                          res_if.verdict, res_if.reason));
            end else begin
                want = verdict_q.pop_front();
                if (res_if.verdict !== want.verdict)
                    report_mismatch($sformatf("verdict %0b, want %0b (%s)",
                                              res_if.verdict, want.verdict,
                                              want.reason.name()));
                if (res_if.reason !== want.reason)
                    report_mismatch($sformatf("reason %0d, want %s",
                                              res_if.reason, want.reason.name()));
            end
        end
    end

    function automatic int find_sender(logic v6, logic [ADDR_W-1:0] hi_in,
                                       logic [ADDR_W-1:0] lo_in);
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        hi = v6 ? hi_in : '0;
        lo = v6 ? lo_in : {32'd0, lo_in[31:0]};
        for (int i = 0; i < SENDER_ENTRIES; i++)
            if (sender_valid[i] && sender_v6[i] == v6 && sender_hi[i] == hi &&
                sender_lo[i] == lo)
                return i;
        return -1;
    endfunction

    // expected outcome of one header; updates the sender table copy
    function automatic t_outcome judge_packet(logic v6, logic tcp,
                                              logic [ADDR_W-1:0] hi_in,
                                              logic [ADDR_W-1:0] lo_in,
                                              logic [PORT_W-1:0] port);
        t_outcome r;
        logic [GUARD_REGS-1:0] act;
        logic guarded;
        int idx;
        act = guard_mask & GUARD_USE;
        guarded = 1'b0;
        for (int i = 0; i < GUARD_REGS; i++)
            if (act[i] && port == guard_port[i])
                guarded = 1'b1;
        r.verdict = VERDICT_DROP;
        if (act == '0) begin
            r.verdict = VERDICT_ACCEPT;
            r.reason  = R_NO_GUARD;
        end else if (!tcp) begin
            r.verdict = VERDICT_ACCEPT;
            r.reason  = R_NOT_TCP;
        end else if (guarded) begin
            idx = find_sender(v6, hi_in, lo_in);
            if (idx >= 0 && sender_step[idx] == PROG_DONE) begin
                r.verdict = VERDICT_ACCEPT;
                r.reason  = R_AUTHORIZED;
            end else begin
                r.reason = R_REFUSED;
            end
        end else if (port != knock_seq[0] && port != knock_seq[1] &&
                     port != knock_seq[2]) begin
            r.verdict = VERDICT_ACCEPT;
            r.reason  = R_UNWATCHED;
        end else begin
            idx = find_sender(v6, hi_in, lo_in);
            if (idx < 0) begin
                for (int i = 0; i < SENDER_ENTRIES; i++)
                    if (!sender_valid[i] && idx < 0)
                        idx = i;
                if (idx >= 0) begin
                    sender_valid[idx] = 1'b1;
                    sender_v6[idx]    = v6;
                    sender_hi[idx]    = v6 ? hi_in : '0;
                    sender_lo[idx]    = v6 ? lo_in : {32'd0, lo_in[31:0]};
                    sender_step[idx]  = 2'd0;
                end
            end
            if (idx < 0) begin
                r.reason = R_TABLE_FULL;
            end else if (sender_step[idx] != PROG_DONE &&
                         port == knock_seq[sender_step[idx]]) begin
                sender_step[idx] = sender_step[idx] + 2'd1;
                r.reason = R_KNOCK_ADV;
            end else begin
                sender_valid[idx] = 1'b0;
                r.reason = R_KNOCK_WRONG;
            end
        end
        return r;
    endfunction

    function automatic int count_senders();
        int n;
        n = 0;
        for (int i = 0; i < SENDER_ENTRIES; i++)
            if (sender_valid[i])
                n++;
        return n;
    endfunction

    function automatic logic [PORT_W-1:0] pick_guard();
        logic [GUARD_REGS-1:0] act;
        int j;
        act = guard_mask & GUARD_USE;
        if (act == '0)
            return PORT_W'($urandom);
        j = $urandom_range(GUARD_REGS - 1);
        while (!act[j])
            j = $urandom_range(GUARD_REGS - 1);
        return guard_port[j];
    endfunction

    // valid is left high on return; the next call or wait_idle decides
    task automatic send_pkt(input logic v6, input logic tcp,
                            input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                            input logic [PORT_W-1:0] port);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pkt_if.valid = 1'b0;
            @(negedge clk);
        end
        pkt_if.valid         = 1'b1;
        pkt_if.ip_version    = v6;
        pkt_if.is_tcp        = tcp;
        pkt_if.src_addr_high = hi;
        pkt_if.src_addr_low  = lo;
        pkt_if.dest_port     = port;
        do @(posedge clk); while (!pkt_if.ready);
        verdict_q.push_back(judge_packet(v6, tcp, hi, lo, port));
    endtask

    // IPv4 sender; bits outside the 32-bit address carry noise
    task automatic send_v4(input logic [31:0] addr, input logic [PORT_W-1:0] port,
                           input logic tcp = 1'b1);
        send_pkt(1'b0, tcp, {$urandom, $urandom}, {$urandom, addr}, port);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        pkt_if.valid = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = r;
        i_cfg_data = val;
        @(negedge clk);
        i_cfg_we   = 1'b0;
        case (r)
            CFG_KNOCK_FIRST:  knock_seq[0] = val;
            CFG_KNOCK_SECOND: knock_seq[1] = val;
            CFG_KNOCK_THIRD:  knock_seq[2] = val;
            CFG_GUARD_A:      guard_port[0] = val;
            CFG_GUARD_B:      guard_port[1] = val;
            CFG_GUARD_C:      guard_port[2] = val;
            CFG_GUARD_D:      guard_port[3] = val;
            CFG_GUARD_MASK:   guard_mask    = val[GUARD_REGS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [PORT_W-1:0] k0, k1, k2,
                               input logic [PORT_W-1:0] g0, g1, g2, g3,
                               input logic [GUARD_REGS-1:0] mask);
        wait_idle();
        set_reg(CFG_KNOCK_FIRST, k0);
        set_reg(CFG_KNOCK_SECOND, k1);
        set_reg(CFG_KNOCK_THIRD, k2);
        set_reg(CFG_GUARD_A, g0);
        set_reg(CFG_GUARD_B, g1);
        set_reg(CFG_GUARD_C, g2);
        set_reg(CFG_GUARD_D, g3);
        set_reg(CFG_GUARD_MASK, CFG_DATA_W'(mask));
    endtask

    // send a wrong knock from every live sender so the table ends up empty
    task automatic clear_senders();
        int st;
        for (int i = 0; i < SENDER_ENTRIES; i++) begin
            if (sender_valid[i]) begin
                st = int'(sender_step[i]);
                send_pkt(sender_v6[i], 1'b1, sender_hi[i], sender_lo[i],
                         (st == PROG_DONE) ? knock_seq[0] : knock_seq[(st + 1) % 3]);
            end
        end
    endtask

    task automatic random_items(input int n);
        int s;
        int sel;
        int idx;
        int st;
        logic v6;
        logic tcp;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [PORT_W-1:0] port;
        for (int k = 0; k < n; k++) begin
            s   = $urandom_range(POOL_SIZE - 1);
            v6  = pool_v6[s];
            hi  = v6 ? pool_hi[s] : {$urandom, $urandom};
            lo  = v6 ? pool_lo[s] : {$urandom, pool_lo[s][31:0]};
            tcp = 1'b1;
            idx = find_sender(v6, hi, lo);
            st  = (idx >= 0) ? int'(sender_step[idx]) : 0;
            sel = $urandom_range(99);
            if (sel < 50) begin
                // next step of a well-formed knock, then use of the guarded port
                port = (st == PROG_DONE) ? pick_guard() : knock_seq[st];
            end else if (sel < 65) begin
                port = pick_guard();
            end else if (sel < 75) begin
                port = knock_seq[$urandom_range(2)];
            end else if (sel < 82) begin
                port = PORT_W'($urandom);
            end else if (sel < 87) begin
                tcp  = 1'b0;
                port = knock_seq[$urandom_range(2)];
            end else begin
                v6   = 1'($urandom_range(1));
                tcp  = 1'($urandom_range(1));
                hi   = {$urandom, $urandom};
                lo   = {$urandom, $urandom};
                port = PORT_W'($urandom);
            end
            send_pkt(v6, tcp, hi, lo, port);
        end
    endtask

    task automatic test_reset_defaults();
        // no guarded port enabled: everything passes, knocks are not recorded
        send_v4(32'h0A00_0001, knock_seq[0]);
        send_pkt(1'b1, 1'b0, '1, '1, 16'hFFFF);
        send_pkt(1'b1, 1'b1, '0, '0, 16'h0000);
    endtask

    task automatic test_filter_basics();
        send_v4(32'h0A00_0001, 16'd22, 1'b0);
        send_pkt(1'b1, 1'b0, '0, '0, knock_seq[1]);
        send_v4(32'hFFFF_FFFF, 16'd1);
        send_pkt(1'b1, 1'b1, '1, '1, 16'd65534);
    endtask

    task automatic test_knock_sequence();
        send_v4(32'h0A00_0001, knock_seq[0]);
        send_v4(32'h0A00_0001, knock_seq[1]);
        send_v4(32'h0A00_0001, 16'd443);
        send_v4(32'h0A00_0001, knock_seq[2]);
        send_v4(32'h0A00_0001, 16'd22);
        send_v4(32'h0A00_0001, 16'd0);
        // same low word as IPv6 is a different sender
        send_pkt(1'b1, 1'b1, '0, 64'h0A00_0001, 16'd22);
        // knock after completion clears the sender
        send_v4(32'h0A00_0001, knock_seq[0]);
        send_v4(32'h0A00_0001, 16'd22);
        // wrong first knock from a new sender leaves nothing behind
        send_v4(32'h0A00_0002, knock_seq[1]);
        send_v4(32'h0A00_0002, 16'd22);
        send_pkt(1'b1, 1'b1, '1, '1, knock_seq[0]);
        send_pkt(1'b1, 1'b1, '1, '1, knock_seq[1]);
        send_pkt(1'b1, 1'b1, '1, '1, knock_seq[2]);
        send_pkt(1'b1, 1'b1, '1, '1, 16'd65535);
    endtask

    task automatic test_guard_over_knock();
        wait_idle();
        set_reg(CFG_GUARD_D, knock_seq[0]);
        send_v4(32'h0A00_0003, knock_seq[0]);
        wait_idle();
        set_reg(CFG_GUARD_D, 16'd443);
        send_v4(32'h0A00_0003, knock_seq[1]);
    endtask

    task automatic test_table_full();
        int k;
        k = 0;
        while (count_senders() < SENDER_ENTRIES) begin
            send_v4(32'hC0A8_0100 + k, knock_seq[0]);
            k++;
        end
        send_v4(32'hC0A8_0300, knock_seq[0]);
        send_pkt(1'b1, 1'b1, 64'h1, 64'h2, knock_seq[0]);
        // known senders still advance while the table is full
        send_v4(32'hC0A8_0100, knock_seq[1]);
        clear_senders();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        random_items(n);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        pkt_if.valid = 1'b0;
        hold_left = 200;
        random_items(24);
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 29;
        random_items(15);
        wait_idle();
        random_items(15);
    endtask

    task automatic build_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_v6[i] = (i >= POOL_V4);
            pool_hi[i] = (i >= POOL_V4) ? {$urandom, $urandom} : '0;
            pool_lo[i] = (i >= POOL_V4) ? {$urandom, $urandom} : {32'd0, $urandom};
        end
        // IPv6 twin of an IPv4 sender
        pool_hi[POOL_V4] = '0;
        pool_lo[POOL_V4] = {32'd0, pool_lo[0][31:0]};
    endtask

    initial begin
        int guard;
        rst_n          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_KNOCK_FIRST;
        i_cfg_data     = '0;
        pkt_if.valid   = 1'b0;
        pkt_if.ip_version    = 1'b0;
        pkt_if.is_tcp        = 1'b0;
        pkt_if.src_addr_high = '0;
        pkt_if.src_addr_low  = '0;
        pkt_if.dest_port     = '0;
        res_if.ready   = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        knock_seq[0]   = KNOCK_FIRST_RST;
        knock_seq[1]   = KNOCK_SECOND_RST;
        knock_seq[2]   = KNOCK_THIRD_RST;
        for (int i = 0; i < GUARD_REGS; i++)
            guard_port[i] = '0;
        guard_mask = '0;
        for (int i = 0; i < SENDER_ENTRIES; i++) begin
            sender_valid[i] = 1'b0;
            sender_v6[i]    = 1'b0;
            sender_hi[i]    = '0;
            sender_lo[i]    = '0;
            sender_step[i]  = 2'd0;
        end
        build_pool();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        apply_setup(16'd2345, 16'd3456, 16'd4567, 16'd22, 16'd0, 16'd65535, 16'd443, 4'hF);
        test_filter_basics();
        test_knock_sequence();
        test_guard_over_knock();
        test_table_full();

        apply_setup(16'd100, 16'd200, 16'd300, 16'd22, 16'd80, 16'd443, 16'd8080, 4'hF);
        test_random_phase(0, 0, 75);
        // extreme ports, repeated knock port, a disabled guard on a knock port
        apply_setup(16'd0, 16'd65535, 16'd0, 16'd1, 16'd65534, 16'd65535, 16'd2, 4'b0011);
        test_random_phase(70, 0, 75);
        apply_setup(16'd777, 16'd777, 16'd777, 16'd1000, 16'd3, 16'd4, 16'd2000, 4'b1001);
        test_random_phase(0, 70, 75);
        apply_setup(16'd5000, 16'd6000, 16'd5000, 16'd5000, 16'd9, 16'd7000, 16'd6000,
                    4'b0100);
        test_random_phase(29, 29, 75);
        test_backpressure();
        test_drain_pause();

        @(negedge clk);
        pkt_if.valid = 1'b0;
        guard = 0;
        while (verdict_q.size() != 0 && guard < 2000) begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/kfilt_pkg.sv
rtl/kfilt_in_if.sv
rtl/kfilt_out_if.sv
rtl/kfilt_front.sv
rtl/kfilt_queue.sv
rtl/kfilt_back.sv
rtl/tcp_port_knock_filter_unit.sv
tb/tb_tcp_port_knock_filter_unit.sv
